/* sv/pls_pkg.sv */
// Shared types and constants for the positional list store.
package pls_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // Field widths of the channels
  localparam int OPC_W   = 2;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Internal widths
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OPC_W-1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_APPEND = 2'd3
  } op_t;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

endpackage

/* sv/pls_if.sv */
// Valid/ready channel interfaces for operations and results.
interface pls_in_if import pls_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface pls_out_if import pls_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VAL_W-1:0]   read_value;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output read_value, output status, output count, input ready);
  modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

/* sv/positional_list_store.sv */
// Top level: bounded ordered list of words with positional insert/remove.
//
// Operations arrive on in_ch (opcode, position, value) and each one gives
// exactly one result on out_ch (read_value, status, count). A transaction
// is taken when valid and ready are both high.
//
// The list is a row of entry cells. Insert shifts every cell past the
// position up by one and remove shifts them down by one, all in the same
// cycle: the result is valid the cycle after the input transaction and
// one operation can be taken per cycle while out_ch is not stalled. The
// read path is a single mux over the cells at the position.
//
// The result sits in an output register. While out_ch is stalled that
// register holds and in_ch.ready drops; in_ch.ready stays high whenever the
// register is empty or is being drained in the same cycle.
//
// Reset (synchronous, active low) empties the list and the output register.
// Entry contents are not cleared; only positions below the count are read.
module positional_list_store import pls_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pls_in_if.sink    in_ch,
  pls_out_if.source out_ch
);

  logic [DATA_WIDTH-1:0] ent [CAPACITY];
  cell_ctl_t             ctl [CAPACITY];

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r;
  logic [VAL_W-1:0]   rd_r, rd_nxt;
  logic [STAT_W-1:0]  st_r, st_nxt;

  logic                  accept;
  logic                  do_ins, do_rem, do_app;
  logic [CMP_W-1:0]      pos_c, cnt_c;
  logic [DATA_WIDTH-1:0] new_word;
  op_t                   op;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign op          = op_t'(in_ch.opcode);
  assign pos_c       = CMP_W'(in_ch.position);
  assign cnt_c       = CMP_W'(cnt_r);
  assign new_word    = DATA_WIDTH'(in_ch.value);

  always_comb begin
    rd_nxt  = '0;
    st_nxt  = ST_DONE;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    do_app  = 1'b0;
    unique case (op)
      OP_READ: begin
        if (pos_c < cnt_c) rd_nxt = VAL_W'(ent[IDX_W'(in_ch.position)]);
        else st_nxt = ST_RANGE;
      end
      OP_INSERT: begin
        // full check wins over the range check
        if (cnt_r == CNT_W'(CAPACITY)) st_nxt = ST_FULL;
        else if (pos_c > cnt_c) st_nxt = ST_RANGE;
        else do_ins = 1'b1;
      end
      OP_REMOVE: begin
        if (pos_c < cnt_c) begin
          rd_nxt = VAL_W'(ent[IDX_W'(in_ch.position)]);
          do_rem = 1'b1;
        end else begin
          st_nxt = ST_RANGE;
        end
      end
      OP_APPEND: begin
        if (cnt_r == CNT_W'(CAPACITY)) st_nxt = ST_FULL;
        else do_app = 1'b1;
      end
      default: st_nxt = ST_RANGE;
    endcase

    cnt_nxt = cnt_r;
    if (accept && (do_ins || do_app)) cnt_nxt = cnt_r + CNT_W'(1);
    else if (accept && do_rem) cnt_nxt = cnt_r - CNT_W'(1);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = ent[i+1];
    end

    always_comb begin
      ctl[i].op = CELL_HOLD;
      if (accept) begin
        if (do_ins) begin
          if (CMP_W'(i) == pos_c) ctl[i].op = CELL_LOAD;
          else if (CMP_W'(i) > pos_c) ctl[i].op = CELL_FROM_LEFT;
        end else if (do_app) begin
          if (CMP_W'(i) == cnt_c) ctl[i].op = CELL_LOAD;
        end else if (do_rem) begin
          if (CMP_W'(i) >= pos_c) ctl[i].op = CELL_FROM_RIGHT;
        end
      end
    end

    pls_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .new_word   (new_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (ent[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= rd_nxt;
      st_r <= st_nxt;
    end
  end

  logic [COUNT_W-1:0] cnt_out_r;
  always_ff @(posedge clk) begin
    if (accept) cnt_out_r <= COUNT_W'(cnt_nxt);
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = rd_r;
  assign out_ch.status     = st_r;
  assign out_ch.count      = cnt_out_r;

endmodule

/* sv/pls_cell.sv */
// One list entry; loads a new word or takes a neighbor's word on a shift.
module pls_cell import pls_pkg::*; (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [DATA_WIDTH-1:0] new_word,
  input  logic [DATA_WIDTH-1:0] left_word,
  input  logic [DATA_WIDTH-1:0] right_word,
  output logic [DATA_WIDTH-1:0] word
);

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;

  always_comb begin
    unique case (ctl.op)
      CELL_LOAD:       word_nxt = new_word;
      CELL_FROM_LEFT:  word_nxt = left_word;
      CELL_FROM_RIGHT: word_nxt = right_word;
      default:         word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

/* sv/pls_checker.sv */
// Port-level checks for the positional list store, bound to the top level.
module pls_checker import pls_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [VAL_W-1:0]   out_read_value,
  input logic [STAT_W-1:0]  out_status,
  input logic [COUNT_W-1:0] out_count
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value)
      && $stable(out_status) && $stable(out_count))
    else $error("result changed while stalled");

  // every transaction yields a result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("transaction gave no result");

  // full status only when the list holds CAPACITY entries
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_count == COUNT_W'(CAPACITY))
    else $error("full status with list not full");

  // rejected operations return zero
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_read_value == '0)
    else $error("rejected operation returned data");

  // ready must return once the result is drained
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind positional_list_store pls_checker u_pls_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_value (out_ch.read_value),
  .out_status     (out_ch.status),
  .out_count      (out_ch.count)
);
